### sv/spibd_pkg.sv
package spibd_pkg;

  localparam int CLK_W    = 32;
  localparam int BAUD_W   = 32;
  localparam int PRE_W    = 8;
  localparam int FIELD_W  = 8;
  localparam int MCAND_W  = BAUD_W + 1;
  localparam int MPLIER_W = 16;
  localparam int PROD_W   = MCAND_W + MPLIER_W;
  localparam int STEP_W   = $clog2(MPLIER_W + 1);

  localparam logic [CLK_W-1:0]   RESET_CLK_HZ = 32'd250000000;
  localparam logic [PRE_W-1:0]   PRE_MIN      = 8'd2;
  localparam logic [PRE_W-1:0]   PRE_MAX      = 8'd254;
  localparam logic [FIELD_W-1:0] FIELD_MAX    = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_POST,
    ST_DONE
  } state_t;

endpackage

### sv/spibd_smul.sv
module spibd_smul import spibd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [MCAND_W-1:0]  mcand,
  input  logic [MPLIER_W-1:0] mplier,
  output logic                done,
  output logic [PROD_W-1:0]   prod
);

  logic [MCAND_W-1:0] mcand_r;
  logic [STEP_W-1:0]  cnt;
  logic [MCAND_W-1:0] addend;
  logic [MCAND_W:0]   sum;
  logic [PROD_W-1:0]  prod_next;

  // one multiplier bit per cycle, lsb first; the multiplier shifts out of the low end
  always_comb begin
    addend    = prod[0] ? mcand_r : '0;
    sum       = {1'b0, prod[PROD_W-1:MPLIER_W]} + {1'b0, addend};
    prod_next = {sum, prod[MPLIER_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == STEP_W'(1)) && !start;
      if (start) begin
        cnt <= STEP_W'(MPLIER_W);
      end else if (cnt != '0) begin
        cnt <= cnt - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      prod    <= {{MCAND_W{1'b0}}, mplier};
    end else if (cnt != '0) begin
      prod <= prod_next;
    end
  end

endmodule

### sv/spi_baud_divider_search_unit.sv
// Serial clock divider search. For each requested rate the unit walks the even
// prescalers 2..254 upward and then the post divider 256..2 downward. Every
// candidate is one product, built by a bit-serial shift-add multiplier that first
// loads its operands and then shifts. An item tries at most 127 prescalers and
// 255 post dividers. Every product comes from the one shared multiplier, so its
// speed sets the search time. The post divider test uses clk >= p * (d - 1) *
// (target + 1), which equals clk / (p * (d - 1)) > target, so no divider is
// needed. One item is worked at a time; a finished result waits in the output
// register while the next item is taken. The input clock register is written
// with cfg_we/cfg_wdata.
module spi_baud_divider_search_unit import spibd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CLK_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BAUD_W-1:0]  target_baud,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PRE_W-1:0]   prescaler,
  output logic [FIELD_W-1:0] serial_rate_field,
  output logic               too_low_error
);

  state_t state, state_next;

  logic [CLK_W-1:0]    clk_hz;
  logic [BAUD_W-1:0]   target;
  logic [PRE_W-1:0]    pre, pre_next;
  logic [FIELD_W-1:0]  fld, fld_next;
  logic [MPLIER_W-1:0] dm, dm_next;
  logic [PRE_W-1:0]    res_pre, res_pre_next;
  logic [FIELD_W-1:0]  res_fld, res_fld_next;
  logic                res_err, res_err_next;

  logic                mul_start;
  logic [MCAND_W-1:0]  mul_mcand;
  logic [MPLIER_W-1:0] mul_mplier;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;

  logic found;
  logic hit;
  logic load_out;

  spibd_smul u_smul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  // clk < (p + 2) * 256 * t  <=>  clk / 256 < (p + 2) * t
  assign found = {{(PROD_W - CLK_W + 8){1'b0}}, clk_hz[CLK_W-1:8]} < mul_prod;
  assign hit   = {{(PROD_W - CLK_W){1'b0}}, clk_hz} >= mul_prod;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    pre_next     = pre;
    fld_next     = fld;
    dm_next      = dm;
    res_pre_next = res_pre;
    res_fld_next = res_fld;
    res_err_next = res_err;
    mul_start    = 1'b0;
    mul_mcand    = {1'b0, target};
    mul_mplier   = '0;
    load_out     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          pre_next   = PRE_MIN;
          mul_start  = 1'b1;
          mul_mcand  = {1'b0, target_baud};
          mul_mplier = MPLIER_W'(PRE_MIN) + MPLIER_W'(2);
          state_next = ST_PRE;
        end
      end
      ST_PRE: begin
        if (mul_done) begin
          priority if (found) begin
            // start the post divider at 256, i.e. p * 255
            fld_next   = FIELD_MAX;
            dm_next    = {pre, 8'd0} - {8'd0, pre};
            mul_start  = 1'b1;
            mul_mcand  = {1'b0, target} + MCAND_W'(1);
            mul_mplier = dm_next;
            state_next = ST_POST;
          end else if (pre == PRE_MAX) begin
            res_pre_next = '0;
            res_fld_next = '0;
            res_err_next = 1'b1;
            state_next   = ST_DONE;
          end else begin
            pre_next   = pre + PRE_W'(2);
            mul_start  = 1'b1;
            mul_mplier = MPLIER_W'(pre) + MPLIER_W'(4);
          end
        end
      end
      ST_POST: begin
        if (mul_done) begin
          priority if (hit || fld == FIELD_W'(1)) begin
            res_pre_next = pre;
            res_fld_next = hit ? fld : '0;
            res_err_next = 1'b0;
            state_next   = ST_DONE;
          end else begin
            fld_next   = fld - FIELD_W'(1);
            dm_next    = dm - MPLIER_W'(pre);
            mul_start  = 1'b1;
            mul_mcand  = {1'b0, target} + MCAND_W'(1);
            mul_mplier = dm_next;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      clk_hz    <= RESET_CLK_HZ;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        clk_hz <= cfg_wdata;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      target <= target_baud;
    end
    pre     <= pre_next;
    fld     <= fld_next;
    dm      <= dm_next;
    res_pre <= res_pre_next;
    res_fld <= res_fld_next;
    res_err <= res_err_next;
    if (load_out) begin
      prescaler         <= res_pre;
      serial_rate_field <= res_fld;
      too_low_error     <= res_err;
    end
  end

endmodule

### tb/spi_baud_divider_checker.sv
`timescale 1ns / 1ps
module spi_baud_divider_checker import spibd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CLK_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [BAUD_W-1:0]  target_baud,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [PRE_W-1:0]   prescaler,
  input  logic [FIELD_W-1:0] serial_rate_field,
  input  logic               too_low_error,
  output int                 mismatches,
  output int                 pending,
  output int                 checked,
  output int                 too_low_seen
);

  typedef struct packed {
    logic [BAUD_W-1:0]  rate;
    logic [PRE_W-1:0]   pre;
    logic [FIELD_W-1:0] field;
    logic               low_err;
  } divider_pick_t;

  divider_pick_t    divider_picks [$];
  divider_pick_t    want;
  logic [CLK_W-1:0] input_clock_hz;

  // smallest even prescaler that brings the rate in reach, then the largest post divider
  function automatic divider_pick_t pick_divider(input logic [CLK_W-1:0] hz,
                                                 input logic [BAUD_W-1:0] baud);
    divider_pick_t pick;
    logic [63:0]   clk64;
    logic [63:0]   rate64;
    logic [63:0]   p;
    logic [63:0]   f;
    pick = '0;
    pick.rate = baud;
    clk64 = 64'(hz);
    rate64 = 64'(baud);
    p = 64'(PRE_MIN);
    while (p <= PRE_MAX && clk64 >= (p + 2) * 256 * rate64) p = p + 2;
    if (p > PRE_MAX) begin
      pick.low_err = 1'b1;
      return pick;
    end
    // f is post divider minus one; the scan bottoms out at zero
    f = 64'(FIELD_MAX);
    while (f > 0 && clk64 / (p * f) <= rate64) f = f - 1;
    pick.pre = p[PRE_W-1:0];
    pick.field = f[FIELD_W-1:0];
    return pick;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      input_clock_hz = RESET_CLK_HZ;
      divider_picks.delete();
      mismatches = 0;
      checked = 0;
      too_low_seen = 0;
    end else begin
      if (cfg_we) input_clock_hz = cfg_wdata;
      if (in_valid && in_ready) divider_picks.push_back(pick_divider(input_clock_hz, target_baud));
      if (out_valid && out_ready) begin
        if (divider_picks.size() == 0) begin
          $display("%0t: result with no request waiting: prescaler %0d field %0d error %0b",
                   $time, prescaler, serial_rate_field, too_low_error);
          mismatches++;
        end else begin
          want = divider_picks.pop_front();
          if (prescaler !== want.pre) begin
            $display("%0t: target %0d prescaler expected %0d actual %0d",
                     $time, want.rate, want.pre, prescaler);
            mismatches++;
          end
          if (serial_rate_field !== want.field) begin
            $display("%0t: target %0d rate field expected %0d actual %0d",
                     $time, want.rate, want.field, serial_rate_field);
            mismatches++;
          end
          if (too_low_error !== want.low_err) begin
            $display("%0t: target %0d too-low flag expected %0b actual %0b",
                     $time, want.rate, want.low_err, too_low_error);
            mismatches++;
          end
          checked++;
          if (want.low_err) too_low_seen++;
        end
      end
    end
    pending = divider_picks.size();
  end

endmodule

### tb/spi_baud_divider_search_unit_test.sv
`timescale 1ns / 1ps
module spi_baud_divider_search_unit_test;
  import spibd_pkg::*;

  localparam int STALL_LIMIT = 50000;
  localparam int HOLD_CYCLES = 3000;
  localparam int PHASE_ITEMS = 18;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [CLK_W-1:0]   cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BAUD_W-1:0]  target_baud = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PRE_W-1:0]   prescaler;
  logic [FIELD_W-1:0] serial_rate_field;
  logic               too_low_error;

  int               mismatches;
  int               pending;
  int               checked;
  int               too_low_seen;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               idle_cycles = 0;
  int               clock_settings = 1;
  bit               hold_req = 1'b0;
  logic [CLK_W-1:0] clk_hz = RESET_CLK_HZ;

  always #1 clk = ~clk;

  spi_baud_divider_search_unit uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .target_baud      (target_baud),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .prescaler        (prescaler),
    .serial_rate_field(serial_rate_field),
    .too_low_error    (too_low_error)
  );

  spi_baud_divider_checker divider_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .target_baud      (target_baud),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .prescaler        (prescaler),
    .serial_rate_field(serial_rate_field),
    .too_low_error    (too_low_error),
    .mismatches       (mismatches),
    .pending          (pending),
    .checked          (checked),
    .too_low_seen     (too_low_seen)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays high across back-to-back transfers
  task automatic offer_target(input logic [BAUD_W-1:0] rate);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    target_baud <= rate;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_clock(input logic [CLK_W-1:0] hz);
    cfg_we <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_we <= 1'b0;
    clk_hz = hz;
    clock_settings++;
  endtask

  function automatic logic [CLK_W-1:0] pick_clock();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(400_000_000, 1_000_000);
      2: return $urandom >> $urandom_range(31);
      default: return RESET_CLK_HZ;
    endcase
  endfunction

  // half the rates near a prescaler or post divider step, half wide-range ones
  function automatic logic [BAUD_W-1:0] aim_target(input logic [CLK_W-1:0] hz);
    logic [63:0] base;
    int unsigned p;
    int unsigned d;
    p = 2 * $urandom_range(127, 1);
    d = $urandom_range(256, 2);
    case ($urandom_range(7))
      0: return $urandom;
      1, 2, 3: return $urandom >> $urandom_range(31);
      4, 5: base = hz / ((p + 2) * 256);
      default: base = hz / (2 * (d - 1));
    endcase
    return BAUD_W'(base + 64'($urandom_range(2)) - 64'd1);
  endfunction

  initial begin
    logic [BAUD_W-1:0] rates [$];
    int ph;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset clock: too-low edge, smallest prescaler edge, post divider edges, extremes
    rates = '{0, 1, clk_hz / 65536, clk_hz / 65536 + 1, clk_hz / 1536, clk_hz / 1024,
              clk_hz / 1024 + 1, clk_hz / 2, clk_hz / 2 + 1, clk_hz, 32'hFFFF_FFFF,
              32'h5555_5555, 32'hAAAA_AAAA};
    foreach (rates[i]) offer_target(rates[i]);
    drain();

    // zero input clock: any nonzero rate lands on prescaler 2, field 0
    set_clock('0);
    rates = '{0, 1, 32'hFFFF_FFFF};
    foreach (rates[i]) offer_target(rates[i]);
    drain();

    set_clock(1);
    rates = '{0, 1, 32'hFFFF_FFFF};
    foreach (rates[i]) offer_target(rates[i]);
    drain();

    set_clock('1);
    rates = '{clk_hz / 65536, clk_hz / 65536 + 1, clk_hz / 1024 + 1, 32'h8000_0000,
              32'hFFFF_FFFF};
    foreach (rates[i]) offer_target(rates[i]);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      set_clock(pick_clock());
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 24) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 24) : 0;
      repeat (PHASE_ITEMS) offer_target(aim_target(clk_hz));
      drain();
    end

    // long hold on the result side while short searches keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_clock(RESET_CLK_HZ);
    hold_req = 1'b1;
    repeat (PHASE_ITEMS) offer_target($urandom_range(2_000_000, 20_000));
    drain();
    repeat (200) @(posedge clk);

    $display("run covered %0d divider searches over %0d input clock settings, %0d too-low",
             checked, clock_settings, too_low_seen);
    $display("idle mixes: none, sender, receiver, both, and a %0d-cycle result hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
sv/spibd_pkg.sv
sv/spibd_smul.sv
sv/spi_baud_divider_search_unit.sv
tb/spi_baud_divider_checker.sv
tb/spi_baud_divider_search_unit_test.sv
